### rtl/core/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

  // Cache geometry. All sizes are powers of two.
  localparam int LINES          = 256;
  localparam int WORDS_PER_LINE = 16;
  localparam int MEMORY_WORDS   = 65536;
  localparam int WORD_BITS      = 32;

  localparam int OFF_W   = $clog2(WORDS_PER_LINE);
  localparam int IDX_W   = $clog2(LINES);
  localparam int MEM_AW  = $clog2(MEMORY_WORDS);
  localparam int TAG_W   = MEM_AW - IDX_W - OFF_W;
  localparam int DATA_AW = IDX_W + OFF_W;

  // Port field widths.
  localparam int ADDR_W      = 18;
  localparam int RWORD_W     = 32;
  localparam int TIME_W      = 32;
  localparam int COST_W      = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int TDATA_IN_W  = 56;
  localparam int TDATA_OUT_W = 64;

  // Access kinds carried in the input tuser.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_READ  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_WRITE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_READ    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_WRITE   = 8'd3;

  // A decoded access waiting between the front and the back.
  typedef struct packed {
    logic                 cmd;
    logic [TAG_W-1:0]     tag;
    logic [IDX_W-1:0]     idx;
    logic [OFF_W-1:0]     off;
    logic [WORD_BITS-1:0] wdata;
  } req_t;

  // Timing costs from the configuration registers.
  typedef struct packed {
    logic [COST_W-1:0] cache_read;
    logic [COST_W-1:0] cache_write;
    logic [COST_W-1:0] mem_read;
    logic [COST_W-1:0] mem_write;
  } cost_t;

  // Status of the back part.
  typedef struct packed {
    logic clearing;
    logic emit;
  } bk_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB_RD,
    ST_WB_WR,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_ACCESS,
    ST_RESP
  } state_e;

endpackage

### rtl/core/direct_mapped_write_back_cache.sv
// Flow: a hit is resolved in the lookup state after the tag and data reads; a miss writes
// a dirty victim line back word by word, fills the line word by word, then does the access
// and, on a read, a response state. A new item is taken only in the idle state, once the
// previous one is done. A two-entry input queue and an output register let either side
// stall on its own. After reset the 65536-word backing memory is cleared, one word a cycle,
// during which no item is accepted; configuration writes are taken at any time.
`timescale 1ns / 1ps

module direct_mapped_write_back_cache (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [dmc_pkg::COST_W-1:0]          cfg_data_i,
  // Input items.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dmc_pkg::TDATA_IN_W-1:0]      s_axis_tdata,  // byte_address, write_word
  input  logic                                s_axis_tuser,  // command
  // Result items.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dmc_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,  // read_word, elapsed_time
  output logic [1:0]                          m_axis_tuser   // was_hit, did_write_back
);

  dmc_pkg::cost_t    cost_q;
  dmc_pkg::req_t     q_data;
  dmc_pkg::bk_stat_t stat;
  logic              q_valid, q_ready;
  logic [dmc_pkg::RWORD_W-1:0] rdata;
  logic [dmc_pkg::TIME_W-1:0]  time_total;
  logic              hit, wb;

  // Timing cost registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q.cache_read  <= 16'd1;
      cost_q.cache_write <= 16'd1;
      cost_q.mem_read    <= 16'd100;
      cost_q.mem_write   <= 16'd50;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmc_pkg::CFG_CACHE_READ:  cost_q.cache_read  <= cfg_data_i;
        dmc_pkg::CFG_CACHE_WRITE: cost_q.cache_write <= cfg_data_i;
        dmc_pkg::CFG_MEM_READ:    cost_q.mem_read    <= cfg_data_i;
        dmc_pkg::CFG_MEM_WRITE:   cost_q.mem_write   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dmc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_i       (stat.clearing),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_data_o      (q_data)
  );

  dmc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cost_i    (cost_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_data_i  (q_data),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_rdata_o (rdata),
    .m_hit_o   (hit),
    .m_wb_o    (wb),
    .m_time_o  (time_total),
    .stat_o    (stat)
  );

  assign m_axis_tdata = {time_total, rdata};
  assign m_axis_tuser = {wb, hit};

`ifndef SYNTHESIS
  // No item is taken while the memory is being cleared.
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready)
    else $error("item accepted during memory clear");

  // A write-back only happens on a miss.
  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("write-back reported on a hit");

  // A result is only produced when the output register is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending result");

  // The queue is never popped during the clear.
  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !q_ready)
    else $error("queue popped during memory clear");
`endif

endmodule

### rtl/core/dmc_ram.sv
`timescale 1ns / 1ps

module dmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/dmc_front.sv
`timescale 1ns / 1ps

module dmc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               block_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [dmc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tuser,
  output logic                               q_valid_o,
  input  logic                               q_ready_i,
  output dmc_pkg::req_t                      q_data_o
);

  logic [dmc_pkg::MEM_AW-1:0] waddr;
  dmc_pkg::req_t              req_in;
  dmc_pkg::req_t              entry_q [2];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [1:0]                 count_q;
  logic                       push, pop;

  // Split the word address into tag, line index and word offset.
  assign waddr        = s_axis_tdata[dmc_pkg::ADDR_W-1:2];
  assign req_in.cmd   = s_axis_tuser;
  assign req_in.off   = waddr[dmc_pkg::OFF_W-1:0];
  assign req_in.idx   = waddr[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
  assign req_in.tag   = waddr[dmc_pkg::MEM_AW-1 -: dmc_pkg::TAG_W];
  assign req_in.wdata = s_axis_tdata[dmc_pkg::ADDR_W +: dmc_pkg::WORD_BITS];

  // Two-entry queue towards the back part.
  assign s_axis_tready = (count_q != 2'd2) && !block_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (count_q != 2'd0);
  assign pop           = q_valid_o && q_ready_i;
  assign q_data_o      = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

### rtl/core/dmc_back.sv
`timescale 1ns / 1ps

module dmc_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dmc_pkg::cost_t                  cost_i,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  dmc_pkg::req_t                   q_data_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [dmc_pkg::RWORD_W-1:0]     m_rdata_o,
  output logic                            m_hit_o,
  output logic                            m_wb_o,
  output logic [dmc_pkg::TIME_W-1:0]      m_time_o,
  output dmc_pkg::bk_stat_t               stat_o
);

  localparam int EXT_W = dmc_pkg::TIME_W - dmc_pkg::COST_W;

  dmc_pkg::state_e state_q, state_d;
  dmc_pkg::req_t   req_q;
  logic [dmc_pkg::OFF_W-1:0]     cnt_q, cnt_d;
  logic [dmc_pkg::TAG_W-1:0]     old_tag_q;
  logic                          wb_q;
  logic [dmc_pkg::TIME_W-1:0]    time_q, time_d;
  logic [dmc_pkg::MEM_AW-1:0]    clr_q;
  logic                          valid_q [dmc_pkg::LINES];
  logic                          dirty_q [dmc_pkg::LINES];
  logic                          out_valid_q;
  logic [dmc_pkg::RWORD_W-1:0]   out_rdata_q, out_rdata_d;
  logic                          out_hit_q, out_hit_d;
  logic                          out_wb_q;
  logic [dmc_pkg::TIME_W-1:0]    out_time_q;

  logic out_free, hit, victim_dirty, cnt_last, emit, take;
  logic fill_done, set_dirty;

  // Memory ports.
  logic [dmc_pkg::TAG_W-1:0]     tag_rdata;
  logic                          tag_we;
  logic [dmc_pkg::IDX_W-1:0]     tag_raddr;
  logic                          data_we;
  logic [dmc_pkg::DATA_AW-1:0]   data_waddr, data_raddr;
  logic [dmc_pkg::WORD_BITS-1:0] data_wdata, data_rdata;
  logic                          mem_we;
  logic [dmc_pkg::MEM_AW-1:0]    mem_waddr, mem_raddr;
  logic [dmc_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;

  dmc_ram #(.WIDTH(dmc_pkg::TAG_W), .DEPTH(dmc_pkg::LINES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (req_q.idx),
    .wdata_i (req_q.tag),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  dmc_ram #(.WIDTH(dmc_pkg::WORD_BITS), .DEPTH(dmc_pkg::LINES * dmc_pkg::WORDS_PER_LINE))
    u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .raddr_i (data_raddr),
    .rdata_o (data_rdata)
  );

  dmc_ram #(.WIDTH(dmc_pkg::WORD_BITS), .DEPTH(dmc_pkg::MEMORY_WORDS)) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Lookup result, valid in the cycle after the tag read.
  assign out_free     = !out_valid_q || m_ready_i;
  assign take         = out_valid_q && m_ready_i;
  assign hit          = valid_q[req_q.idx] && (tag_rdata == req_q.tag);
  assign victim_dirty = valid_q[req_q.idx] && dirty_q[req_q.idx];
  assign cnt_last     = (cnt_q == {dmc_pkg::OFF_W{1'b1}});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmc_pkg::ST_CLEAR: begin
        if (clr_q == {dmc_pkg::MEM_AW{1'b1}}) state_d = dmc_pkg::ST_IDLE;
      end
      dmc_pkg::ST_IDLE: begin
        if (q_valid_i && out_free) state_d = dmc_pkg::ST_LOOKUP;
      end
      dmc_pkg::ST_LOOKUP: begin
        if (hit) begin
          state_d = dmc_pkg::ST_IDLE;
        end else if (victim_dirty) begin
          state_d = dmc_pkg::ST_WB_RD;
        end else begin
          state_d = dmc_pkg::ST_FILL_RD;
        end
      end
      dmc_pkg::ST_WB_RD:   state_d = dmc_pkg::ST_WB_WR;
      dmc_pkg::ST_WB_WR: begin
        state_d = cnt_last ? dmc_pkg::ST_FILL_RD : dmc_pkg::ST_WB_RD;
      end
      dmc_pkg::ST_FILL_RD: state_d = dmc_pkg::ST_FILL_WR;
      dmc_pkg::ST_FILL_WR: begin
        state_d = cnt_last ? dmc_pkg::ST_ACCESS : dmc_pkg::ST_FILL_RD;
      end
      dmc_pkg::ST_ACCESS: begin
        state_d = (req_q.cmd == dmc_pkg::CMD_WRITE) ? dmc_pkg::ST_IDLE : dmc_pkg::ST_RESP;
      end
      dmc_pkg::ST_RESP:    state_d = dmc_pkg::ST_IDLE;
      default:             state_d = dmc_pkg::ST_IDLE;
    endcase
  end

  // Memory control, timing total and result.
  always_comb begin
    q_ready_o   = 1'b0;
    tag_we      = 1'b0;
    tag_raddr   = q_data_i.idx;
    data_we     = 1'b0;
    data_waddr  = {req_q.idx, req_q.off};
    data_wdata  = req_q.wdata;
    data_raddr  = {q_data_i.idx, q_data_i.off};
    mem_we      = 1'b0;
    mem_waddr   = {old_tag_q, req_q.idx, cnt_q};
    mem_wdata   = data_rdata;
    mem_raddr   = {req_q.tag, req_q.idx, cnt_q};
    cnt_d       = cnt_q;
    time_d      = time_q;
    emit        = 1'b0;
    fill_done   = 1'b0;
    set_dirty   = 1'b0;
    out_rdata_d = '0;
    out_hit_d   = 1'b0;
    case (state_q)
      dmc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      dmc_pkg::ST_IDLE: begin
        q_ready_o = out_free;
      end
      dmc_pkg::ST_LOOKUP: begin
        if (hit) begin
          emit      = 1'b1;
          out_hit_d = 1'b1;
          if (req_q.cmd == dmc_pkg::CMD_WRITE) begin
            data_we   = 1'b1;
            set_dirty = 1'b1;
          end else begin
            out_rdata_d = data_rdata[dmc_pkg::RWORD_W-1:0];
          end
        end else begin
          time_d = time_q + {{EXT_W{1'b0}}, cost_i.mem_read}
                 + (victim_dirty ? {{EXT_W{1'b0}}, cost_i.mem_write} : '0);
        end
      end
      dmc_pkg::ST_WB_RD: begin
        data_raddr = {req_q.idx, cnt_q};
      end
      dmc_pkg::ST_WB_WR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      dmc_pkg::ST_FILL_WR: begin
        data_we    = 1'b1;
        data_waddr = {req_q.idx, cnt_q};
        data_wdata = mem_rdata;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_last) begin
          tag_we    = 1'b1;
          fill_done = 1'b1;
        end
      end
      dmc_pkg::ST_ACCESS: begin
        data_raddr = {req_q.idx, req_q.off};
        if (req_q.cmd == dmc_pkg::CMD_WRITE) begin
          data_we   = 1'b1;
          set_dirty = 1'b1;
          emit      = 1'b1;
        end
      end
      dmc_pkg::ST_RESP: begin
        emit        = 1'b1;
        out_rdata_d = data_rdata[dmc_pkg::RWORD_W-1:0];
      end
      default: begin
      end
    endcase
    if (emit) begin
      time_d = time_q + {{EXT_W{1'b0}}, cost_i.cache_read}
             + ((req_q.cmd == dmc_pkg::CMD_WRITE) ? {{EXT_W{1'b0}}, cost_i.cache_write} : '0);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmc_pkg::ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < dmc_pkg::LINES; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      time_q  <= time_d;
      if (state_q == dmc_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (fill_done) begin
        valid_q[req_q.idx] <= 1'b1;
        dirty_q[req_q.idx] <= 1'b0;
      end else if (set_dirty) begin
        dirty_q[req_q.idx] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (q_ready_o && q_valid_i) begin
      req_q <= q_data_i;
    end
    if (state_q == dmc_pkg::ST_LOOKUP) begin
      old_tag_q <= tag_rdata;
      wb_q      <= !hit && victim_dirty;
    end
    if (emit) begin
      out_rdata_q <= out_rdata_d;
      out_hit_q   <= out_hit_d;
      out_wb_q    <= (state_q == dmc_pkg::ST_LOOKUP) ? 1'b0 : wb_q;
      out_time_q  <= time_d;
    end
  end

  assign m_valid_o       = out_valid_q;
  assign m_rdata_o       = out_rdata_q;
  assign m_hit_o         = out_hit_q;
  assign m_wb_o          = out_wb_q;
  assign m_time_o        = out_time_q;
  assign stat_o.clearing = (state_q == dmc_pkg::ST_CLEAR);
  assign stat_o.emit     = emit;

endmodule
